// ===== hw/rtl/gathered_attention_scores_assert.svh =====
// Assertion macros for the gathered attention score block.
`ifndef GATHERED_ATTENTION_SCORES_ASSERT_SVH
`define GATHERED_ATTENTION_SCORES_ASSERT_SVH

`ifndef SYNTHESIS

`define GAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GAS_ASSERT(lbl, clk, rst_n, prop, msg)

`define GAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/gas_pkg.sv =====
package gas_pkg;

    localparam int MODE_W     = 2;
    localparam int ROW_W      = 8;
    localparam int ELEM_IDX_W = 6;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int SCORE_W    = 40;
    localparam int DIM_CFG_W  = 7;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCORE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/gathered_attention_scores.sv =====
// Sparse attention score unit. Modes 0 and 1 write one key or query element
// while busy stays low. Mode 2 scores the query buffer against one gathered
// key row on a single multiply-accumulate unit, one element pair per cycle,
// reading the key and query memories through one registered port each. Busy
// rises after the start beat, and the score appears with o_strobe in the last
// busy cycle; a row beyond MAX_KEYS or a length of zero goes straight to the
// result beat. The receiver cannot stall: o_strobe lasts exactly one cycle
// and the score must be taken then. The length register is writable only
// while busy is low; memories are not cleared by reset, so every entry must
// be written before it is scored.
`include "gathered_attention_scores_assert.svh"

module gathered_attention_scores #(
    parameter int MAX_KEYS = 256,
    parameter int MAX_DIM  = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [gas_pkg::MODE_W-1:0]     i_mode,
    input  logic        [gas_pkg::ROW_W-1:0]      i_row_index,
    input  logic        [gas_pkg::ELEM_IDX_W-1:0] i_element_index,
    input  logic signed [gas_pkg::ELEM_W-1:0]     i_element_value,
    output logic                                  o_strobe,
    output logic signed [gas_pkg::SCORE_W-1:0]    o_score,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [gas_pkg::DIM_CFG_W-1:0]  i_cfg_data
);

    localparam int KEY_DEPTH = MAX_KEYS * MAX_DIM;
    localparam int KA_W      = $clog2(KEY_DEPTH);
    localparam int QA_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int SUM_W     = gas_pkg::PROD_W + $clog2(MAX_DIM) + 1;
    localparam int ACC_W     = (SUM_W > gas_pkg::SCORE_W) ? SUM_W : gas_pkg::SCORE_W;

    gas_pkg::t_state r_state, n_state;

    logic [gas_pkg::DIM_CFG_W-1:0] r_dim;

    logic signed [gas_pkg::ELEM_W-1:0] r_key_mem [KEY_DEPTH];
    logic signed [gas_pkg::ELEM_W-1:0] r_qry_mem [MAX_DIM];
    logic signed [gas_pkg::ELEM_W-1:0] r_k_rd;
    logic signed [gas_pkg::ELEM_W-1:0] r_q_rd;

    logic [KA_W-1:0]  r_kaddr;
    logic [QA_W-1:0]  r_qaddr;
    logic [CNT_W-1:0] r_left;
    logic             r_rd_v;
    logic             r_prod_v;

    logic signed [gas_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]           r_acc;

    logic             accept;
    logic             row_ok;
    logic             elem_ok;
    logic             key_we;
    logic             qry_we;
    logic             score_req;
    logic [CNT_W-1:0] len;
    logic [KA_W-1:0]  row_base;
    logic [KA_W-1:0]  key_waddr;
    logic             sat_fits;

    assign accept    = start && (r_state == gas_pkg::ST_IDLE);
    assign row_ok    = 32'(i_row_index) < MAX_KEYS;
    assign elem_ok   = 32'(i_element_index) < MAX_DIM;
    assign key_we    = accept && (i_mode == gas_pkg::MODE_KEY) && row_ok && elem_ok;
    assign qry_we    = accept && (i_mode == gas_pkg::MODE_QUERY) && elem_ok;
    assign score_req = accept && (i_mode == gas_pkg::MODE_SCORE);
    assign len       = (32'(r_dim) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_dim);
    assign row_base  = KA_W'(KA_W'(i_row_index) * KA_W'(MAX_DIM));
    assign key_waddr = KA_W'(row_base + KA_W'(i_element_index));
    assign sat_fits  = (&r_acc[ACC_W-1:gas_pkg::SCORE_W-1])
                    || !(|r_acc[ACC_W-1:gas_pkg::SCORE_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gas_pkg::ST_IDLE: begin
                if (score_req) begin
                    n_state = (row_ok && (len != '0)) ? gas_pkg::ST_ISSUE : gas_pkg::ST_OUT;
                end
            end
            gas_pkg::ST_ISSUE: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = gas_pkg::ST_DRAIN;
                end
            end
            gas_pkg::ST_DRAIN: begin
                if (!r_rd_v && !r_prod_v) begin
                    n_state = gas_pkg::ST_OUT;
                end
            end
            gas_pkg::ST_OUT: begin
                n_state = gas_pkg::ST_IDLE;
            end
            default: begin
                n_state = gas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = (r_state != gas_pkg::ST_IDLE);
        o_cfg_ready = (r_state == gas_pkg::ST_IDLE);
        o_strobe    = (r_state == gas_pkg::ST_OUT);
        if (sat_fits) begin
            o_score = r_acc[gas_pkg::SCORE_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_score = {1'b1, {(gas_pkg::SCORE_W-1){1'b0}}};
        end else begin
            o_score = {1'b0, {(gas_pkg::SCORE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= gas_pkg::DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dim <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_waddr] <= i_element_value;
        end
        if (r_state == gas_pkg::ST_ISSUE) begin
            r_k_rd <= r_key_mem[r_kaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_we) begin
            r_qry_mem[QA_W'(i_element_index)] <= i_element_value;
        end
        if (r_state == gas_pkg::ST_ISSUE) begin
            r_q_rd <= r_qry_mem[r_qaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kaddr  <= '0;
            r_qaddr  <= '0;
            r_left   <= '0;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= (r_state == gas_pkg::ST_ISSUE);
            r_prod_v <= r_rd_v;
            if (score_req) begin
                r_kaddr <= row_base;
                r_qaddr <= '0;
                r_left  <= len;
            end else if (r_state == gas_pkg::ST_ISSUE) begin
                r_kaddr <= KA_W'(r_kaddr + KA_W'(1));
                r_qaddr <= QA_W'(r_qaddr + QA_W'(1));
                r_left  <= CNT_W'(r_left - CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= r_q_rd * r_k_rd;
        end
        if (score_req) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= ACC_W'(r_acc + ACC_W'(r_prod));
        end
    end

    `GAS_ASSERT_NEXT(a_score_goes_busy, i_clk, i_rst_n, score_req, busy, "score request did not raise busy")
    `GAS_ASSERT_NEXT(a_write_one_cycle, i_clk, i_rst_n, key_we || qry_we, !busy && !o_strobe, "element write produced a beat or busy")
    `GAS_ASSERT_NEXT(a_strobe_releases, i_clk, i_rst_n, o_strobe, !busy && !o_strobe, "result beat not followed by idle")
    `GAS_ASSERT(a_prod_in_run, i_clk, i_rst_n, !r_prod_v || r_state == gas_pkg::ST_ISSUE || r_state == gas_pkg::ST_DRAIN, "product valid outside a score run")
    `GAS_ASSERT(a_cfg_not_in_run, i_clk, i_rst_n, !(o_cfg_ready && (o_strobe || r_rd_v || r_prod_v)), "config ready while a score run is active")

endmodule

// ===== tb/gathered_attention_scores_tb.sv =====
`timescale 1ns / 1ps

class score_tracker;
    bit [gas_pkg::ELEM_W-1:0] key_mem [0:256*64-1];
    bit [gas_pkg::ELEM_W-1:0] query_mem [0:63];
    bit [gas_pkg::DIM_CFG_W-1:0] dim_len;
    logic [gas_pkg::SCORE_W-1:0] pending_scores [$];
    int errors;

    function new();
        dim_len = gas_pkg::DIM_RESET;
        errors = 0;
    endfunction

    task report(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    function void set_length(input bit [gas_pkg::DIM_CFG_W-1:0] len);
        dim_len = len;
    endfunction

    function logic [gas_pkg::SCORE_W-1:0] dot_score(input bit [gas_pkg::ROW_W-1:0] row);
        longint acc;
        longint hi;
        longint lo;
        int n;
        acc = 0;
        hi = (longint'(1) <<< (gas_pkg::SCORE_W - 1)) - 1;
        lo = -hi - 1;
        n = (dim_len > 64) ? 64 : int'(dim_len);
        for (int i = 0; i < n; i++) begin
            acc += longint'($signed(query_mem[i])) * longint'($signed(key_mem[int'(row) * 64 + i]));
        end
        if (acc > hi) acc = hi;
        if (acc < lo) acc = lo;
        return acc[gas_pkg::SCORE_W-1:0];
    endfunction

    task note_item(input logic [gas_pkg::MODE_W-1:0] mode,
                   input logic [gas_pkg::ROW_W-1:0] row,
                   input logic [gas_pkg::ELEM_IDX_W-1:0] elem,
                   input logic [gas_pkg::ELEM_W-1:0] val);
        case (mode)
            gas_pkg::MODE_KEY: key_mem[int'(row) * 64 + int'(elem)] = val;
            gas_pkg::MODE_QUERY: query_mem[elem] = val;
            gas_pkg::MODE_SCORE: pending_scores.push_back(dot_score(row));
            default: ;
        endcase
    endtask

    task check_score(input logic [gas_pkg::SCORE_W-1:0] got);
        logic [gas_pkg::SCORE_W-1:0] want;
        if (pending_scores.size() == 0) begin
            report($sformatf("unexpected score %0d", $signed(got)));
        end else begin
            want = pending_scores.pop_front();
            if (got !== want)
                report($sformatf("score got %0d expected %0d", $signed(got), $signed(want)));
        end
    endtask
endclass

module gathered_attention_scores_tb;

    localparam logic [gas_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ROWS = 256;
    localparam int DIMS = 64;
    localparam int ITEM_TARGET = 850;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [gas_pkg::MODE_W-1:0] i_mode = '0;
    logic [gas_pkg::ROW_W-1:0] i_row_index = '0;
    logic [gas_pkg::ELEM_IDX_W-1:0] i_element_index = '0;
    logic signed [gas_pkg::ELEM_W-1:0] i_element_value = '0;
    logic i_cfg_valid = 1'b0;
    logic [gas_pkg::DIM_CFG_W-1:0] i_cfg_data = '0;
    logic busy;
    logic o_strobe;
    logic signed [gas_pkg::SCORE_W-1:0] o_score;
    logic o_cfg_ready;

    score_tracker tracker;
    bit key_done [0:ROWS-1][0:DIMS-1];
    bit query_done [0:DIMS-1];
    bit [gas_pkg::ROW_W-1:0] ready_rows [$];
    int cur_len = DIMS;
    int items_sent = 0;
    int burst_left = 0;

    gathered_attention_scores uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_row_index(i_row_index),
        .i_element_index(i_element_index),
        .i_element_value(i_element_value),
        .o_strobe(o_strobe),
        .o_score(o_score),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                tracker.note_item(i_mode, i_row_index, i_element_index, i_element_value);
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_length(i_cfg_data);
            if (o_strobe)
                tracker.check_score(o_score);
        end
    end

    initial begin
        #10_000_000;
        $display("[gathered_attention_scores] ERROR");
        $finish;
    end

    function bit [gas_pkg::ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return gas_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // drop start between bursts
    task pace();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task send_item(input logic [gas_pkg::MODE_W-1:0] mode,
                   input logic [gas_pkg::ROW_W-1:0] row,
                   input logic [gas_pkg::ELEM_IDX_W-1:0] elem,
                   input logic [gas_pkg::ELEM_W-1:0] val);
        pace();
        start <= 1'b1;
        i_mode <= mode;
        i_row_index <= row;
        i_element_index <= elem;
        i_element_value <= val;
        do @(posedge i_clk); while (busy);
        if (mode != MODE_UNUSED) items_sent++;
        if (mode == gas_pkg::MODE_KEY) key_done[row][elem] = 1'b1;
        if (mode == gas_pkg::MODE_QUERY) query_done[elem] = 1'b1;
    endtask

    task write_length(input int len);
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (tracker.pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len[gas_pkg::DIM_CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = (len > DIMS) ? DIMS : len;
    endtask

    // fill any unwritten entries the score would read, then request it
    task score_row(input bit [gas_pkg::ROW_W-1:0] row);
        for (int i = 0; i < cur_len; i++) begin
            if (!query_done[i])
                send_item(gas_pkg::MODE_QUERY, gas_pkg::ROW_W'($urandom),
                          gas_pkg::ELEM_IDX_W'(i), pick_value());
            if (!key_done[row][i])
                send_item(gas_pkg::MODE_KEY, row, gas_pkg::ELEM_IDX_W'(i), pick_value());
        end
        send_item(gas_pkg::MODE_SCORE, row, gas_pkg::ELEM_IDX_W'($urandom),
                  gas_pkg::ELEM_W'($urandom));
        ready_rows.push_back(row);
        if (ready_rows.size() > 8) void'(ready_rows.pop_front());
    endtask

    function bit [gas_pkg::ROW_W-1:0] pick_row();
        if (ready_rows.size() != 0 && $urandom_range(0, 3) != 0)
            return ready_rows[$urandom_range(0, ready_rows.size() - 1)];
        return gas_pkg::ROW_W'($urandom);
    endfunction

    task random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            score_row(pick_row());
        else if (pick < 70)
            send_item(gas_pkg::MODE_KEY, pick_row(), gas_pkg::ELEM_IDX_W'($urandom),
                      pick_value());
        else if (pick < 95)
            send_item(gas_pkg::MODE_QUERY, gas_pkg::ROW_W'($urandom),
                      gas_pkg::ELEM_IDX_W'($urandom), pick_value());
        else
            send_item(MODE_UNUSED, gas_pkg::ROW_W'($urandom),
                      gas_pkg::ELEM_IDX_W'($urandom), gas_pkg::ELEM_W'($urandom));
    endtask

    initial begin
        int lens [4];
        int len;
        int phase;
        int phase_end;
        lens = '{1, 127, 64, 3};
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_length(2);
        send_item(gas_pkg::MODE_QUERY, 8'h00, 6'd0, 16'h7FFF);
        send_item(gas_pkg::MODE_QUERY, 8'hFF, 6'd1, 16'h8000);
        send_item(gas_pkg::MODE_KEY, 8'd0, 6'd0, 16'h7FFF);
        send_item(gas_pkg::MODE_KEY, 8'd0, 6'd1, 16'h7FFF);
        send_item(gas_pkg::MODE_KEY, 8'd255, 6'd0, 16'h8000);
        send_item(gas_pkg::MODE_KEY, 8'd255, 6'd1, 16'h8000);
        send_item(gas_pkg::MODE_SCORE, 8'd0, 6'd0, 16'h0000);
        send_item(gas_pkg::MODE_SCORE, 8'd255, 6'd63, 16'hFFFF);
        send_item(gas_pkg::MODE_KEY, 8'd170, 6'd0, 16'hFFFF);
        send_item(gas_pkg::MODE_KEY, 8'd170, 6'd1, 16'h0001);
        send_item(gas_pkg::MODE_SCORE, 8'd170, 6'd21, 16'h5555);
        send_item(MODE_UNUSED, 8'd85, 6'd63, 16'h5555);
        send_item(gas_pkg::MODE_KEY, 8'd85, 6'd63, 16'h5A5A);
        send_item(gas_pkg::MODE_QUERY, 8'd0, 6'd63, 16'hFFFF);
        write_length(0);
        send_item(gas_pkg::MODE_SCORE, 8'd85, 6'd42, 16'hAAAA);
        send_item(gas_pkg::MODE_SCORE, 8'd0, 6'd0, 16'h0000);
        write_length(1);
        send_item(gas_pkg::MODE_SCORE, 8'd255, 6'd0, 16'h0000);
        ready_rows.push_back(8'd0);
        ready_rows.push_back(8'd255);
        ready_rows.push_back(8'd170);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 4) begin
                len = lens[phase];
            end else begin
                case ($urandom_range(0, 19))
                    0: len = 0;
                    1, 2, 3: len = $urandom_range(65, 127);
                    4, 5, 6, 7, 8: len = $urandom_range(9, 64);
                    default: len = $urandom_range(1, 8);
                endcase
            end
            write_length(len);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET) random_item();
            phase++;
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_scores.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("[gathered_attention_scores] OK");
        else
            $display("[gathered_attention_scores] ERROR");
        $finish;
    end
endmodule
